FILE: rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and codes for the sorted table search unit
// Operation and status codes, cell select and sequencer state types.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned ENTRY_W = 5;

  // operation codes; the unused code behaves as a search
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_PREV,
    SEL_NEXT,
    SEL_LOAD
  } cell_sel_t;

  typedef struct packed {
    logic      cmp_en;
    cell_sel_t sel;
  } cell_ctl_t;

  typedef struct packed {
    logic ins;
    logic del;
  } shift_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// A full-table insert or an empty-table delete goes straight to loading the
// result beat; otherwise the sequencer probes one cell per cycle, an insert or
// a delete that finds its key then shifts the chain, and the result beat is
// loaded. No new item is taken until the last result beat is loaded, so a held
// result beat stalls the next item.
// Reset clears the entry count and control; stored keys stay undefined.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit: sorted key table with search, insert, delete
// A chain of key cells compared in parallel, walked by a binary search
// sequencer, shifting up or down by one slot per insert or delete.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [1:0] op, [33:2] key, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // [1:0] status, [5:2] position,
                                   // [10:6] entries_now, [15:11] zero
);
  import stbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                    in_fire;
  logic [OP_W-1:0]         in_op;
  logic signed [KEY_W-1:0] in_key;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] bus_key;
  logic signed [KEY_W-1:0] cell_key [TABLE_DEPTH];
  cell_ctl_t               cell_ctl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  lt_vec;
  logic [TABLE_DEPTH-1:0]  eq_vec;
  shift_cmd_t              shift_cmd;
  logic [IDX_W-1:0]        shift_idx;
  logic [STAT_W-1:0]       out_status;
  logic [POS_W-1:0]        out_pos;
  logic [ENTRY_W-1:0]      out_entries;

  assign in_fire = in_tvalid && in_tready;
  assign in_op   = in_tdata[OP_W-1:0];
  assign in_key  = in_tdata[OP_W+KEY_W-1:OP_W];
  // compare against the incoming key, load the held key during the shift
  assign bus_key = in_fire ? in_key : key_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= in_key;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [IDX_W-1:0] CI = IDX_W'(i);
    logic signed [KEY_W-1:0] prev_key;
    logic signed [KEY_W-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_key = bus_key;
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    always_comb begin
      cell_ctl[i].cmp_en = in_fire;
      cell_ctl[i].sel    = SEL_HOLD;
      if (shift_cmd.ins) begin
        if (CI > shift_idx) begin
          cell_ctl[i].sel = SEL_PREV;
        end else if (CI == shift_idx) begin
          cell_ctl[i].sel = SEL_LOAD;
        end
      end else if (shift_cmd.del) begin
        if (CI >= shift_idx) begin
          cell_ctl[i].sel = SEL_NEXT;
        end
      end
    end

    stbs_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .bus_key  (bus_key),
      .prev_key (prev_key),
      .next_key (next_key),
      .key_q    (cell_key[i]),
      .lt_q     (lt_vec[i]),
      .eq_q     (eq_vec[i])
    );
  end

  stbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_op       (in_op),
    .in_tready   (in_tready),
    .lt_vec      (lt_vec),
    .eq_vec      (eq_vec),
    .shift_cmd   (shift_cmd),
    .shift_idx   (shift_idx),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_status),
    .out_pos     (out_pos),
    .out_entries (out_entries)
  );

  assign out_tdata = {5'd0, out_entries, out_pos, out_status};

endmodule

FILE: rtl/core/stbs_cell.sv
// ----------------------------------------------------------------------------
// stbs_cell: one slot of the sorted key chain
// Holds a key, compares it with the broadcast key and shifts to or from
// its neighbours.
// ----------------------------------------------------------------------------
module stbs_cell (
  input  logic                                 clk,
  input  stbs_pkg::cell_ctl_t                  ctl,
  input  logic signed [stbs_pkg::KEY_W-1:0]    bus_key,
  input  logic signed [stbs_pkg::KEY_W-1:0]    prev_key,
  input  logic signed [stbs_pkg::KEY_W-1:0]    next_key,
  output logic signed [stbs_pkg::KEY_W-1:0]    key_q,
  output logic                                 lt_q,
  output logic                                 eq_q
);
  import stbs_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;
  logic                    lt_r;
  logic                    eq_r;

  always_comb begin
    case (ctl.sel)
      SEL_PREV: key_nxt = prev_key;
      SEL_NEXT: key_nxt = next_key;
      SEL_LOAD: key_nxt = bus_key;
      default:  key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctl.cmp_en) begin
      lt_r <= (bus_key < key_r);
      eq_r <= (bus_key == key_r);
    end
  end

  assign key_q = key_r;
  assign lt_q  = lt_r;
  assign eq_q  = eq_r;

endmodule

FILE: rtl/core/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl: search sequencer and result stage
// Probes one cell per cycle for search, delete and insert position, then
// issues the shift for an insert or a found delete and holds the result beat until taken.
// ----------------------------------------------------------------------------
module stbs_ctrl #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned IDX_W       = $clog2(TABLE_DEPTH),
  parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  logic [stbs_pkg::OP_W-1:0]       in_op,
  output logic                            in_tready,
  input  logic [TABLE_DEPTH-1:0]          lt_vec,
  input  logic [TABLE_DEPTH-1:0]          eq_vec,
  output stbs_pkg::shift_cmd_t            shift_cmd,
  output logic [IDX_W-1:0]                shift_idx,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [stbs_pkg::STAT_W-1:0]     out_status,
  output logic [stbs_pkg::POS_W-1:0]      out_pos,
  output logic [stbs_pkg::ENTRY_W-1:0]    out_entries
);
  import stbs_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;   // one past the upper bound
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_stat_r;
  logic [IDX_W-1:0]   out_pos_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_load;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [IDX_W-1:0]   mid_idx;
  logic               is_ins;
  logic               is_del;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - {{CNT_W{1'b0}}, 1'b1};
  assign mid     = mid_sum[CNT_W:1];
  assign mid_idx = mid[IDX_W-1:0];
  assign is_ins  = (op_r == OP_INSERT);
  assign is_del  = (op_r == OP_DELETE);

  // next state and working registers
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    stat_nxt  = stat_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_op;
          lo_nxt   = '0;
          hi_nxt   = cnt_r;
          stat_nxt = ST_OK;
          pos_nxt  = '0;
          state_nxt = S_PROBE;
          if (in_op == OP_INSERT && cnt_r >= DEPTH_C) begin
            stat_nxt  = ST_FULL;
            state_nxt = S_DONE;
          end else if (in_op == OP_DELETE && cnt_r == '0) begin
            stat_nxt  = ST_EMPTY;
            state_nxt = S_DONE;
          end
        end
      end
      S_PROBE: begin
        if (lo_r >= hi_r) begin
          if (is_ins) begin
            pos_nxt   = lo_r[IDX_W-1:0];
            state_nxt = S_SHIFT;
          end else begin
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end else if (is_ins) begin
          // lower bound: advance past keys smaller than the new one
          if (!lt_vec[mid_idx] && !eq_vec[mid_idx]) begin
            lo_nxt = mid + CNT_W'(1);
          end else begin
            hi_nxt = mid;
          end
        end else if (eq_vec[mid_idx]) begin
          pos_nxt   = mid_idx;
          state_nxt = is_del ? S_SHIFT : S_DONE;
        end else if (lt_vec[mid_idx]) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        cnt_nxt   = is_ins ? cnt_r + CNT_W'(1) : cnt_r - CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake and shift outputs
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    out_load      = (state_r == S_DONE) && (!out_valid_r || out_tready);
    shift_cmd.ins = (state_r == S_SHIFT) && is_ins;
    shift_cmd.del = (state_r == S_SHIFT) && is_del;
    shift_idx     = pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    stat_r <= stat_nxt;
    pos_r  <= pos_nxt;
    if (out_load) begin
      out_stat_r <= stat_r;
      out_pos_r  <= pos_r;
      out_cnt_r  <= cnt_r;
    end
  end

  logic [IDX_W+POS_W-1:0]   pos_wide;
  logic [CNT_W+ENTRY_W-1:0] cnt_wide;

  assign pos_wide    = {{POS_W{1'b0}}, out_pos_r};
  assign cnt_wide    = {{ENTRY_W{1'b0}}, out_cnt_r};
  assign out_tvalid  = out_valid_r;
  assign out_status  = out_stat_r;
  assign out_pos     = pos_wide[POS_W-1:0];
  assign out_entries = cnt_wide[ENTRY_W-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> lo_r <= hi_r)
    else $error("probe bounds crossed");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && is_ins |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not raise the count");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result beat not presented");

endmodule

FILE: test/tb_sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_unit: self-checking bench for the sorted table
// Drives search, insert and delete beats with random idling on both streams
// and checks every result against a table model of its own.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_unit;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int LONG_HOLD   = 400;
  localparam logic [OP_W-1:0]         OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   position;
    logic [ENTRY_W-1:0] entries_now;
  } outcome_t;

  // Mirror of the key table; computes the outcome of each accepted request.
  class table_scoreboard;
    logic signed [KEY_W-1:0] keys [TABLE_DEPTH];
    int                      entry_cnt;
    outcome_t                expected_q [$];
    int unsigned             errors;

    function new();
      entry_cnt = 0;
      errors    = 0;
      foreach (keys[i]) keys[i] = '0;
    endfunction

    // first match probed by the binary search, or -1
    function int probe(logic signed [KEY_W-1:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = entry_cnt - 1;
      while (hi >= lo) begin
        mid = (lo + hi) / 2;
        if (k == keys[mid]) return mid;
        if (k < keys[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
      return -1;
    endfunction

    function void log_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k);
      outcome_t o;
      int       found;
      int       p;
      o.status   = ST_OK;
      o.position = '0;
      if (op == OP_INSERT) begin
        if (entry_cnt >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          p = 0;
          while (p < entry_cnt && k > keys[p]) p++;
          for (int i = entry_cnt; i > p; i--) keys[i] = keys[i-1];
          keys[p] = k;
          entry_cnt++;
          o.position = POS_W'(p);
        end
      end else if (op == OP_DELETE) begin
        if (entry_cnt == 0) begin
          o.status = ST_EMPTY;
        end else begin
          found = probe(k);
          if (found < 0) begin
            o.status = ST_NOT_FOUND;
          end else begin
            for (int i = found + 1; i < entry_cnt; i++) keys[i-1] = keys[i];
            entry_cnt--;
            o.position = POS_W'(found);
          end
        end
      end else begin
        // the unused code searches as well
        found = probe(k);
        if (found < 0) o.status = ST_NOT_FOUND;
        else o.position = POS_W'(found);
      end
      o.entries_now = ENTRY_W'(entry_cnt);
      expected_q.push_back(o);
    endfunction

    function void check_result(logic [15:0] data);
      outcome_t want;
      outcome_t got;
      got.status      = data[1:0];
      got.position    = data[5:2];
      got.entries_now = data[10:6];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d position %0d entries %0d",
                 $time, got.status, got.position, got.entries_now);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position mismatch: expected %0d actual %0d",
                 $time, want.position, got.position);
        errors++;
      end
      if (got.entries_now !== want.entries_now) begin
        $display("%0t: entry count mismatch: expected %0d actual %0d",
                 $time, want.entries_now, got.entries_now);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [1:0] op, [33:2] key, [39:34] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [1:0] status, [5:2] position,
                                  // [10:6] entries_now, [15:11] zero

  bit idle_on       = 1'b1;
  bit long_hold_req = 1'b0;

  table_scoreboard sb = new();

  sorted_table_binary_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // result side: ready runs, short stalls and the occasional long hold
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic idle_gap(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the beat until it is taken, then note it
  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, key, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.log_request(op, key);
    if (idle_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
  endtask

  // mostly keys already held or small values, so that hits and duplicates are common
  function automatic logic signed [KEY_W-1:0] pick_key(input logic [OP_W-1:0] op);
    int roll;
    roll = $urandom_range(0, 99);
    if (sb.entry_cnt > 0 && roll < ((op == OP_INSERT) ? 20 : 60))
      return sb.keys[$urandom_range(0, sb.entry_cnt - 1)];
    if (roll < 75) return int'($urandom_range(0, 12)) - 6;
    if (roll < 80) return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
    return $urandom();
  endfunction

  task automatic random_phase(input int n_items, input int ins_pct, input int del_pct);
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    int                      roll;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = OP_INSERT;
      else if (roll < ins_pct + del_pct) op = OP_DELETE;
      else if (roll < 95) op = OP_SEARCH;
      else op = OP_UNUSED;
      key = pick_key(op);
      send_item(op, key);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table cases
    send_item(OP_SEARCH, 0);
    send_item(OP_DELETE, 5);
    send_item(OP_UNUSED, KEY_MIN);
    // extremes, duplicates and the unused code
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, -1);
    send_item(OP_SEARCH, 0);
    send_item(OP_UNUSED, KEY_MIN);
    send_item(OP_SEARCH, KEY_MAX);
    send_item(OP_DELETE, 12345);
    send_item(OP_DELETE, 0);
    // fill to the top, then knock on a full table
    for (int i = 1; i <= 12; i++) send_item(OP_INSERT, i * 1000 - 5500);
    send_item(OP_INSERT, 7);
    send_item(OP_DELETE, KEY_MIN);

    // cycle through filling, mixed and draining phases of 50 beats
    for (int ph = 0; ph < 29; ph++) begin
      if (ph >= 26) idle_on = 1'b0;
      else idle_on = (ph % 5 != 3);
      if (ph == 6 || ph == 17) long_hold_req = 1'b1;
      if (ph == 10 || ph == 21) begin
        // pause until the block has drained
        idle_gap(1);
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      case (ph % 3)
        0: random_phase(50, 60, 20);
        1: random_phase(50, 35, 35);
        default: random_phase(50, 15, 65);
      endcase
    end

    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
